>>> rtl/hst_pkg.sv
`default_nettype none
package hst_pkg;

  // velocity history ring
  localparam int RING_DEPTH = 32;
  localparam int PTR_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int VEL_SHIFT  = 5;

  // field and register widths
  localparam int CODE_W   = 3;
  localparam int POS_W    = 32;
  localparam int VEL_W    = 16;
  localparam int STEP_W   = 16;
  localparam int LIMIT_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int DIV_W    = 10;
  localparam int MAP_W    = 21;
  localparam int CFG_W    = 21;
  localparam int CFG_IDX_W = 2;

  // reset values of the configuration registers
  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd2;
  localparam logic [DIV_W-1:0]   UNDER_RESET = 10'd20;
  localparam logic [MAP_W-1:0]   MAP_RESET   = 21'd967344;

  // hall codes that never come from a working sensor
  localparam logic [CODE_W-1:0] CODE_LOW_BAD  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_HIGH_BAD = 3'd7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE   = 2'd0,
    REG_ERROR_LIMIT = 2'd1,
    REG_UNDERSAMPLE = 2'd2,
    REG_SECTOR_MAP  = 2'd3
  } cfg_reg_t;

  // outcome of a change between two hall codes
  typedef enum logic [1:0] {
    JUMP_NONE = 2'd0,
    JUMP_FWD  = 2'd1,
    JUMP_BACK = 2'd2,
    JUMP_BAD  = 2'd3
  } jump_t;

  // rows: previous accepted code, columns: new code
  localparam jump_t JUMP_TABLE [8][8] = '{
    '{JUMP_NONE, JUMP_NONE, JUMP_NONE, JUMP_NONE,
      JUMP_NONE, JUMP_NONE, JUMP_NONE, JUMP_BAD },
    '{JUMP_BAD,  JUMP_NONE, JUMP_BAD,  JUMP_FWD,
      JUMP_BAD,  JUMP_BACK, JUMP_BAD,  JUMP_BAD },
    '{JUMP_BAD,  JUMP_BAD,  JUMP_NONE, JUMP_BACK,
      JUMP_BAD,  JUMP_BAD,  JUMP_FWD,  JUMP_BAD },
    '{JUMP_BAD,  JUMP_BACK, JUMP_FWD,  JUMP_NONE,
      JUMP_BAD,  JUMP_BAD,  JUMP_BAD,  JUMP_BAD },
    '{JUMP_BAD,  JUMP_BAD,  JUMP_BAD,  JUMP_BAD,
      JUMP_NONE, JUMP_FWD,  JUMP_BACK, JUMP_BAD },
    '{JUMP_BAD,  JUMP_FWD,  JUMP_BAD,  JUMP_BAD,
      JUMP_BACK, JUMP_NONE, JUMP_BAD,  JUMP_BAD },
    '{JUMP_BAD,  JUMP_BAD,  JUMP_BACK, JUMP_BAD,
      JUMP_FWD,  JUMP_BAD,  JUMP_NONE, JUMP_BAD },
    '{JUMP_BAD,  JUMP_BAD,  JUMP_BAD,  JUMP_BAD,
      JUMP_BAD,  JUMP_BAD,  JUMP_BAD,  JUMP_BAD }
  };

  // result of the hall read step for one item
  typedef struct packed {
    logic [CODE_W-1:0] hall_state;
    logic              value_fault;
    logic              sequence_fault;
    logic [POS_W-1:0]  position;
  } hall_result_t;

endpackage
`default_nettype wire

>>> rtl/hall_sensor_position_tracker_top.sv
`default_nettype none
// Hall sensor position tracker. Each input item is one PWM tick with the three
// hall bits; each produces exactly one result item with the accepted hall state,
// its commutation sector, the 32-bit position and the ring-based velocity, plus
// one-tick fault flags. The block takes one item per clock: the hall read step
// and the velocity step sit combinationally between an input holding register
// and the output register, so a new item is accepted every cycle while the
// output side keeps up, and one more is held while a finished result waits.
// The user must write configuration registers via cfg_we/cfg_addr/cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module hall_sensor_position_tracker_top
  import hst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,  // [2:0] hall_code
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [2:0] hall_state, [5:3] sector, [37:6] position, [53:38] velocity,
  // [54] value_fault, [55] sequence_fault
  output logic [55:0]                m_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  logic [STEP_W-1:0]  step_size;
  logic [LIMIT_W-1:0] error_limit;
  logic [DIV_W-1:0]   undersample;
  logic [MAP_W-1:0]   sector_map;

  logic               in_full;
  logic [CODE_W-1:0]  in_code;
  logic               advance;
  hall_result_t       res;
  logic [VEL_W-1:0]   velocity;
  logic [23:0]        map_padded;
  logic [4:0]         map_base;
  logic [2:0]         sector;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size   <= STEP_RESET;
      error_limit <= LIMIT_RESET;
      undersample <= UNDER_RESET;
      sector_map  <= MAP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_STEP_SIZE:   step_size   <= cfg_wdata[STEP_W-1:0];
        REG_ERROR_LIMIT: error_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_UNDERSAMPLE: undersample <= cfg_wdata[DIV_W-1:0];
        REG_SECTOR_MAP:  sector_map  <= cfg_wdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // process the held item when the output slot is free or being emptied
  assign advance  = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || advance;

  // input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_code <= s_tdata[CODE_W-1:0];
    end
  end

  hst_hall_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .code        (in_code),
    .step_size   (step_size),
    .error_limit (error_limit),
    .res         (res)
  );

  hst_velocity u_velocity (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .position    (res.position),
    .undersample (undersample),
    .velocity    (velocity)
  );

  // sector lookup from the configurable map
  assign map_padded = {3'b000, sector_map};
  assign map_base   = {2'b00, res.hall_state} * 5'd3;
  assign sector     = map_padded[map_base +: 3];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.sequence_fault, res.value_fault, velocity, res.position,
                  sector, res.hall_state};
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_full |-> s_tready)
    else $error("input refused while holding register is empty");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed item produced no result");

endmodule
`default_nettype wire

>>> rtl/hst_hall_decode.sv
`default_nettype none
module hst_hall_decode
  import hst_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [CODE_W-1:0]   code,
  input  wire logic [STEP_W-1:0]   step_size,
  input  wire logic [LIMIT_W-1:0]  error_limit,
  output hall_result_t             res
);

  logic [CODE_W-1:0]  last_hall, last_hall_next;
  logic [COUNT_W-1:0] bad_value_count, bad_value_count_next;
  logic [COUNT_W-1:0] bad_jump_count, bad_jump_count_next;
  logic [POS_W-1:0]   position_acc, position_acc_next;

  logic [POS_W-1:0]   step_ext;
  logic [COUNT_W-1:0] limit_ext;
  jump_t              jump;

  assign step_ext  = {{(POS_W-STEP_W){step_size[STEP_W-1]}}, step_size};
  assign limit_ext = {1'b0, error_limit};
  assign jump      = JUMP_TABLE[last_hall][code];

  // read step: tolerate or fault on bad codes and jumps, step the position
  always_comb begin
    last_hall_next       = last_hall;
    bad_value_count_next = bad_value_count;
    bad_jump_count_next  = bad_jump_count;
    position_acc_next    = position_acc;
    res.hall_state       = last_hall;
    res.value_fault      = 1'b0;
    res.sequence_fault   = 1'b0;
    if (code == CODE_LOW_BAD || code == CODE_HIGH_BAD) begin
      if (bad_value_count > limit_ext) begin
        last_hall_next  = '0;
        res.hall_state  = '0;
        res.value_fault = 1'b1;
      end else begin
        bad_value_count_next = bad_value_count + COUNT_W'(1);
      end
    end else begin
      bad_value_count_next = '0;
      if (code != last_hall) begin
        if (jump == JUMP_BAD) begin
          if (bad_jump_count > limit_ext) begin
            last_hall_next     = '0;
            res.hall_state     = '0;
            res.sequence_fault = 1'b1;
          end else begin
            bad_jump_count_next = bad_jump_count + COUNT_W'(1);
          end
        end else begin
          bad_jump_count_next = '0;
          case (jump)
            JUMP_FWD:  position_acc_next = position_acc + step_ext;
            JUMP_BACK: position_acc_next = position_acc - step_ext;
            default:   position_acc_next = position_acc;
          endcase
          last_hall_next = code;
          res.hall_state = code;
        end
      end
    end
    res.position = position_acc_next;
  end

  // hold state between items
  always_ff @(posedge clk) begin
    if (rst) begin
      last_hall       <= '0;
      bad_value_count <= '0;
      bad_jump_count  <= '0;
      position_acc    <= '0;
    end else if (fire) begin
      last_hall       <= last_hall_next;
      bad_value_count <= bad_value_count_next;
      bad_jump_count  <= bad_jump_count_next;
      position_acc    <= position_acc_next;
    end
  end

  a_value_fault_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.value_fault |=> last_hall == '0)
    else $error("value fault did not clear the hall state");

  a_seq_fault_clears: assert property (@(posedge clk) disable iff (rst)
    fire && res.sequence_fault |=> last_hall == '0 && bad_value_count == '0)
    else $error("sequence fault left stale state");

  a_one_fault: assert property (@(posedge clk) disable iff (rst)
    !(res.value_fault && res.sequence_fault))
    else $error("both fault kinds in one item");

endmodule
`default_nettype wire

>>> rtl/hst_velocity.sv
`default_nettype none
module hst_velocity
  import hst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [POS_W-1:0]  position,
  input  wire logic [DIV_W-1:0]  undersample,
  output logic      [VEL_W-1:0]  velocity
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [POS_W-1:0] ring [RING_DEPTH];
  logic [PTR_W-1:0] ring_pointer, ring_pointer_next;
  logic [PTR_W-1:0] ring_pointer_after, rd_addr;
  logic             ring_full;
  logic [DIV_W-1:0] tick_divider, tick_divider_next, div_inc;
  logic [VEL_W-1:0] speed_reg, speed_reg_next;
  logic             sample;
  logic             oldest_written;
  logic [POS_W-1:0] oldest_q;
  logic [POS_W-1:0] oldest, diff, diff_sh;

  assign div_inc           = tick_divider + DIV_W'(1);
  assign sample            = div_inc == undersample;
  assign ring_pointer_next = (ring_pointer == PTR_LAST) ? '0 : ring_pointer + PTR_W'(1);

  // prefetch address: the entry after the write slot as it stands after this edge
  assign ring_pointer_after = (fire && sample) ? ring_pointer_next : ring_pointer;
  assign rd_addr            = (ring_pointer_after == PTR_LAST) ? '0
                                                               : ring_pointer_after + PTR_W'(1);

  // the entry after the write slot is unwritten until the ring first fills
  assign oldest_written = ring_full || ring_pointer == PTR_LAST;
  assign oldest         = oldest_written ? oldest_q : '0;
  assign diff           = position - oldest;
  assign diff_sh        = $signed(diff) >>> VEL_SHIFT;

  always_comb begin
    tick_divider_next = sample ? '0 : div_inc;
    speed_reg_next    = sample ? diff_sh[VEL_W-1:0] : speed_reg;
  end

  assign velocity = speed_reg_next;

  // advance divider, pointer and speed
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider <= '0;
      ring_pointer <= '0;
      ring_full    <= 1'b0;
      speed_reg    <= '0;
    end else if (fire) begin
      tick_divider <= tick_divider_next;
      speed_reg    <= speed_reg_next;
      if (sample) begin
        ring_pointer <= ring_pointer_next;
        if (ring_pointer == PTR_LAST) begin
          ring_full <= 1'b1;
        end
      end
    end
  end

  // store the sampled position and fetch the oldest entry
  always_ff @(posedge clk) begin
    if (fire && sample) begin
      ring[ring_pointer] <= position;
    end
    oldest_q <= ring[rd_addr];
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ring_pointer <= PTR_LAST)
    else $error("ring pointer out of range");

endmodule
`default_nettype wire
